/* rtl/matrix4_multiply_macros.svh */
// Assertion macros shared by the matrix multiplier RTL.
`ifndef MATRIX4_MULTIPLY_MACROS_SVH
`define MATRIX4_MULTIPLY_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define M4M_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("matrix4_multiply assertion failed");
// Next-cycle implication.
`define M4M_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("matrix4_multiply assertion failed");
`else
`define M4M_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define M4M_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* rtl/m4m_pkg.sv */
// Shared types and constants of the 4x4 matrix multiplier.
`default_nettype none
package m4m_pkg;
   localparam int VALUE_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   localparam int PROD_WIDTH  = 2 * VALUE_WIDTH;
   localparam int ACC_WIDTH   = PROD_WIDTH + 2;

   localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic [VALUE_WIDTH-1:0] VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   localparam logic [1:0] FUNC_LOAD_LEFT  = 2'd0;
   localparam logic [1:0] FUNC_LOAD_RIGHT = 2'd1;
   localparam logic [1:0] FUNC_COMPUTE    = 2'd2;

   localparam logic [3:0] LAST_INDEX = 4'd15;

   // Tag that travels with each product term through the datapath.
   typedef struct packed {
      logic       vld;
      logic [3:0] idx;
      logic       first;
      logic       fin;
   } m4m_tag_type;

   typedef struct packed {
      logic done;
   } m4m_status_type;
endpackage
`default_nettype wire

/* rtl/m4m_store.sv */
// One 16-entry element store with a registered read port and per-entry valid bits.
`default_nettype none
module m4m_store
   import m4m_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   wr_en,
   input  wire logic [3:0]             wr_addr,
   input  wire logic [VALUE_WIDTH-1:0] wr_data,
   input  wire logic [3:0]             rd_addr,
   output logic      [VALUE_WIDTH-1:0] rd_data
);
   logic [VALUE_WIDTH-1:0] mem [16];
   logic [15:0]            vld_ff;
   logic [VALUE_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // Entries never written since reset read as zero.
      rd_data_ff <= vld_ff[rd_addr] ? mem[rd_addr] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

/* rtl/m4m_mac.sv */
// Multiply, accumulate, round and saturate stages of the matrix multiplier.
`default_nettype none
module m4m_mac
   import m4m_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire m4m_tag_type            s1_tag,
   input  wire logic [VALUE_WIDTH-1:0] left_data,
   input  wire logic [VALUE_WIDTH-1:0] right_data,
   output m4m_status_type              status,
   output logic                        rsp_valid,
   output logic [3:0]                  rsp_result_index,
   output logic [VALUE_WIDTH-1:0]      rsp_result_value,
   output logic                        rsp_saturated,
   output logic                        rsp_last
);
   m4m_tag_type                  s2_tag_ff;
   m4m_tag_type                  s3_tag_ff;
   logic signed [PROD_WIDTH-1:0] prod_ff;
   logic signed [PROD_WIDTH-1:0] prod_in;
   logic signed [ACC_WIDTH-1:0]  acc_ff;
   logic signed [ACC_WIDTH-1:0]  acc_in;
   logic signed [ACC_WIDTH-1:0]  shifted;
   logic [ACC_WIDTH-VALUE_WIDTH:0] upper;
   logic                         fits;
   logic                         neg;
   logic                         emit;
   logic                         rsp_valid_ff;
   logic [3:0]                   rsp_index_ff;
   logic [VALUE_WIDTH-1:0]       rsp_value_ff;
   logic [VALUE_WIDTH-1:0]       value_in;
   logic                         rsp_sat_ff;
   logic                         rsp_last_ff;

   always_comb begin
      prod_in = signed'(left_data) * signed'(right_data);
      acc_in  = s2_tag_ff.first ? ACC_WIDTH'(prod_ff) : acc_ff + ACC_WIDTH'(prod_ff);
   end

   // The arithmetic shift floors; the result fits when all bits above the
   // value's sign bit agree with it.
   always_comb begin
      shifted  = acc_ff >>> FRAC_BITS;
      upper    = shifted[ACC_WIDTH-1:VALUE_WIDTH-1];
      fits     = (&upper) || !(|upper);
      neg      = acc_ff[ACC_WIDTH-1];
      value_in = fits ? shifted[VALUE_WIDTH-1:0] : (neg ? VALUE_MIN : VALUE_MAX);
      emit     = s3_tag_ff.vld && s3_tag_ff.fin;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_tag_ff    <= '0;
         s3_tag_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_tag_ff    <= s1_tag;
         s3_tag_ff    <= s2_tag_ff;
         rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (s2_tag_ff.vld) begin
         acc_ff <= acc_in;
      end
      if (emit) begin
         rsp_index_ff <= s3_tag_ff.idx;
         rsp_value_ff <= value_in;
         rsp_sat_ff   <= !fits;
         rsp_last_ff  <= (s3_tag_ff.idx == LAST_INDEX);
      end
   end

   assign status.done      = emit && (s3_tag_ff.idx == LAST_INDEX);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_saturated    = rsp_sat_ff;
   assign rsp_last         = rsp_last_ff;
endmodule
`default_nettype wire

/* rtl/matrix4_multiply.sv */
// Loads are taken one per cycle while busy is low; a compute beat keeps busy high until its last result.
// Its results follow in element order, each the sum of four product terms fed
// through the single multiplier and one read port per store.
// Results are strobed for one cycle each; the receiver cannot stall them.
// Synchronous active-high reset clears both stores to zero at once.
`default_nettype none
module matrix4_multiply
   import m4m_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [1:0]             req_func,
   input  wire logic [3:0]             req_element_index,
   input  wire logic [VALUE_WIDTH-1:0] req_element_value,
   output logic                        rsp_valid,
   output logic [3:0]                  rsp_result_index,
   output logic [VALUE_WIDTH-1:0]      rsp_result_value,
   output logic                        rsp_saturated,
   output logic                        rsp_last
);
`include "matrix4_multiply_macros.svh"

   logic                   accept;
   logic                   busy_ff;
   logic                   issuing_ff;
   logic [5:0]             cnt_ff;
   logic [1:0]             term;
   logic [3:0]             elem;
   logic [3:0]             left_addr;
   logic [3:0]             right_addr;
   logic [VALUE_WIDTH-1:0] left_data;
   logic [VALUE_WIDTH-1:0] right_data;
   m4m_tag_type            s1_tag_ff;
   m4m_tag_type            s1_tag_in;
   m4m_status_type         status;

   assign accept = start && !busy_ff;
   assign term   = cnt_ff[1:0];
   assign elem   = cnt_ff[5:2];

   // Element (row, col) sums left[i*4+row] * right[col*4+i] over i.
   assign left_addr  = {term, elem[1:0]};
   assign right_addr = {elem[3:2], term};

   always_comb begin
      s1_tag_in.vld   = issuing_ff;
      s1_tag_in.idx   = elem;
      s1_tag_in.first = (term == 2'd0);
      s1_tag_in.fin   = (term == 2'd3);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         issuing_ff <= 1'b0;
         cnt_ff     <= '0;
         s1_tag_ff  <= '0;
      end else begin
         s1_tag_ff <= s1_tag_in;
         if (accept && (req_func == FUNC_COMPUTE)) begin
            busy_ff    <= 1'b1;
            issuing_ff <= 1'b1;
            cnt_ff     <= '0;
         end else begin
            if (issuing_ff) begin
               cnt_ff <= cnt_ff + 6'd1;
               if (&cnt_ff) begin
                  issuing_ff <= 1'b0;
               end
            end
            if (status.done) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   m4m_store u_left (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept && (req_func == FUNC_LOAD_LEFT)),
      .wr_addr (req_element_index),
      .wr_data (req_element_value),
      .rd_addr (left_addr),
      .rd_data (left_data)
   );

   m4m_store u_right (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept && (req_func == FUNC_LOAD_RIGHT)),
      .wr_addr (req_element_index),
      .wr_data (req_element_value),
      .rd_addr (right_addr),
      .rd_data (right_data)
   );

   m4m_mac u_mac (
      .clock            (clock),
      .reset            (reset),
      .s1_tag           (s1_tag_ff),
      .left_data        (left_data),
      .right_data       (right_data),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_result_index (rsp_result_index),
      .rsp_result_value (rsp_result_value),
      .rsp_saturated    (rsp_saturated),
      .rsp_last         (rsp_last)
   );

   assign busy = busy_ff;

   `M4M_ASSERT_NXT(a_compute_sets_busy, clock, reset, accept && (req_func == FUNC_COMPUTE), busy)
   `M4M_ASSERT_NOW(a_rsp_while_busy, clock, reset, rsp_valid, $past(busy_ff))
   `M4M_ASSERT_NOW(a_last_on_final, clock, reset, rsp_valid, rsp_last == (rsp_result_index == LAST_INDEX))
   `M4M_ASSERT_NOW(a_sat_extreme, clock, reset, rsp_valid && rsp_saturated, (rsp_result_value == VALUE_MAX) || (rsp_result_value == VALUE_MIN))
   `M4M_ASSERT_NOW(a_no_issue_idle, clock, reset, issuing_ff, busy_ff)
endmodule
`default_nettype wire

/* verif/matrix4_multiply_tb.sv */
// Self-checking testbench for the 4x4 fixed-point matrix multiplier: random loads and computes.
module matrix4_multiply_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import m4m_pkg::*;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   typedef struct {
      logic [3:0]             index;
      logic [VALUE_WIDTH-1:0] value;
      logic                   saturated;
      logic                   last;
   } product_beat_type;

   // Mirrors both matrix stores and holds the product beats still owed by the block.
   class product_board;
      logic signed [VALUE_WIDTH-1:0] left_m[16];
      logic signed [VALUE_WIDTH-1:0] right_m[16];
      product_beat_type              expected_products[$];
      int                            errors;

      function new();
         foreach (left_m[k]) begin
            left_m[k]  = '0;
            right_m[k] = '0;
         end
         errors = 0;
      endfunction

      // Row of the left matrix times column of the right one, floored, then saturated.
      function product_beat_type product_element(int k);
         logic signed [ACC_WIDTH-1:0] sum;
         logic signed [ACC_WIDTH-1:0] a;
         logic signed [ACC_WIDTH-1:0] b;
         logic signed [ACC_WIDTH-1:0] floored;
         product_beat_type            r;
         sum = '0;
         for (int i = 0; i < 4; i++) begin
            a   = left_m[i * 4 + k % 4];
            b   = right_m[(k / 4) * 4 + i];
            sum = sum + a * b;
         end
         floored     = sum >>> FRAC_BITS;
         r.index     = k[3:0];
         r.last      = (k == 15);
         r.saturated = 1'b1;
         if (floored > $signed({{(ACC_WIDTH - VALUE_WIDTH){1'b0}}, VALUE_MAX}))
            r.value = VALUE_MAX;
         else if (floored < $signed({{(ACC_WIDTH - VALUE_WIDTH){1'b1}}, VALUE_MIN}))
            r.value = VALUE_MIN;
         else begin
            r.value     = floored[VALUE_WIDTH-1:0];
            r.saturated = 1'b0;
         end
         return r;
      endfunction

      function void note_beat(logic [1:0] func, logic [3:0] idx, logic [VALUE_WIDTH-1:0] val);
         case (func)
            FUNC_LOAD_LEFT: left_m[idx] = val;
            FUNC_LOAD_RIGHT: right_m[idx] = val;
            FUNC_COMPUTE: begin
               for (int k = 0; k < 16; k++)
                  expected_products.push_back(product_element(k));
            end
            default: ;
         endcase
      endfunction

      function void compare_field(string field, logic [VALUE_WIDTH-1:0] want,
                                  logic [VALUE_WIDTH-1:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_product(logic [3:0] idx, logic [VALUE_WIDTH-1:0] val,
                                  logic sat, logic fin);
         product_beat_type want;
         if (expected_products.size() == 0) begin
            $display("%0t: unexpected product beat, expected none actual index %0d value %h",
                     $time, idx, val);
            errors++;
            return;
         end
         want = expected_products.pop_front();
         compare_field("result_index", 32'(want.index), 32'(idx));
         compare_field("result_value", want.value, val);
         compare_field("saturated", 32'(want.saturated), 32'(sat));
         compare_field("last", 32'(want.last), 32'(fin));
      endfunction

      function int pending();
         return expected_products.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [1:0]             req_func;
   logic [3:0]             req_element_index;
   logic [VALUE_WIDTH-1:0] req_element_value;
   logic                   rsp_valid;
   logic [3:0]             rsp_result_index;
   logic [VALUE_WIDTH-1:0] rsp_result_value;
   logic                   rsp_saturated;
   logic                   rsp_last;

   product_board board;
   int           burst_left;

   matrix4_multiply u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_element_index (req_element_index),
      .req_element_value (req_element_value),
      .rsp_valid         (rsp_valid),
      .rsp_result_index  (rsp_result_index),
      .rsp_result_value  (rsp_result_value),
      .rsp_saturated     (rsp_saturated),
      .rsp_last          (rsp_last)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         board.check_product(rsp_result_index, rsp_result_value, rsp_saturated, rsp_last);
   end

   // The sender runs in bursts; between bursts start drops for a random number of cycles.
   task automatic pace();
      int gap;
      if (burst_left > 0)
         burst_left--;
      else begin
         gap = $urandom_range(1, 6);
         @(negedge clock) start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30)
                                                  : $urandom_range(0, 8);
      end
   endtask

   task automatic send_beat(logic [1:0] func, logic [3:0] idx, logic [VALUE_WIDTH-1:0] val);
      @(negedge clock);
      start             <= 1'b1;
      req_func          <= func;
      req_element_index <= idx;
      req_element_value <= val;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_beat(func, idx, val);
      pace();
   endtask

   task automatic wait_for_products();
      @(negedge clock) start <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   // Half are small Q16.16 values so sums stay in range; the rest are random words, single bits or the extremes.
   function automatic logic [VALUE_WIDTH-1:0] random_element();
      logic [VALUE_WIDTH-1:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: begin
            v = $urandom_range(0, 32'h0004_FFFF);
            if ($urandom_range(0, 1) == 1)
               v = -v;
         end
         5, 6: v = $urandom;
         7: v = VALUE_MAX;
         8: v = VALUE_MIN;
         default: begin
            v = 32'd1 << $urandom_range(0, 31);
            if ($urandom_range(0, 1) == 1)
               v = ~v;
         end
      endcase
      return v;
   endfunction

   initial begin
      int beats;
      int round;
      int nloads;
      board             = new();
      reset             = 1'b1;
      start             = 1'b0;
      req_func          = FUNC_LOAD_LEFT;
      req_element_index = '0;
      req_element_value = '0;
      beats             = 0;
      round             = 0;
      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Directed beats, sent back to back.
      burst_left = 1000;
      send_beat(FUNC_COMPUTE, 4'd0, '0);
      send_beat(FUNC_UNUSED, 4'd15, 32'hFFFF_FFFF);
      send_beat(FUNC_LOAD_LEFT, 4'd0, VALUE_MAX);
      send_beat(FUNC_LOAD_LEFT, 4'd15, VALUE_MIN);
      send_beat(FUNC_LOAD_RIGHT, 4'd0, VALUE_MAX);
      send_beat(FUNC_LOAD_RIGHT, 4'd15, VALUE_MIN);
      send_beat(FUNC_LOAD_LEFT, 4'd12, VALUE_MAX);
      send_beat(FUNC_LOAD_LEFT, 4'd5, 32'h0001_0000);
      send_beat(FUNC_LOAD_RIGHT, 4'd5, 32'hFFFF_FFFF);
      // Half times the smallest negative step must floor to minus one step.
      send_beat(FUNC_LOAD_LEFT, 4'd10, 32'h0000_8000);
      send_beat(FUNC_LOAD_RIGHT, 4'd10, 32'hFFFF_FFFF);
      send_beat(FUNC_UNUSED, 4'd0, '0);
      send_beat(FUNC_COMPUTE, 4'd15, 32'hFFFF_FFFF);
      burst_left = 0;
      beats      = 13;

      while (beats < 130) begin
         if (round == 3) begin
            for (int k = 0; k < 16; k++) begin
               send_beat(FUNC_LOAD_LEFT, 4'(k), random_element());
               send_beat(FUNC_LOAD_RIGHT, 4'(k), random_element());
            end
            beats += 32;
         end
         nloads = $urandom_range(0, 10);
         repeat (nloads) begin
            if ($urandom_range(0, 11) == 0) begin
               send_beat(FUNC_UNUSED, 4'($urandom_range(0, 15)), $urandom);
               beats++;
            end else begin
               send_beat(($urandom_range(0, 1) == 1) ? FUNC_LOAD_RIGHT : FUNC_LOAD_LEFT,
                         4'($urandom_range(0, 15)), random_element());
               beats++;
            end
         end
         send_beat(FUNC_COMPUTE, 4'($urandom_range(0, 15)), $urandom);
         beats++;
         round++;
         if (round == 6)
            wait_for_products();
      end

      wait_for_products();
      repeat (80) @(posedge clock);
      if (board.errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
